### src/tks_pkg.sv
// Shared types, constants and functions for the top-k score selector.
package tks_pkg;

  localparam int CapacityDef = 1024;
  localparam int KeepW       = 11;
  localparam int BoostW      = 32;
  localparam int KeyW        = 32;
  localparam int ScoreW      = 32;
  localparam int HeldW       = 11;
  localparam int CfgAddrW    = 3;
  localparam int CfgDataW    = 32;

  localparam logic [KeepW-1:0]  KeepReset  = 11'd1024;
  localparam logic [BoostW-1:0] BoostReset = 32'd65536;

  localparam logic CfgKeep  = 1'b0;
  localparam logic CfgBoost = 1'b1;

  localparam logic ActPop = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ScoreW-1:0] score;
  } entry_t;

  typedef struct packed {
    logic              action;
    logic [KeyW-1:0]   term_key;
    logic [ScoreW-1:0] score;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [KeyW-1:0]   out_key;
    logic [ScoreW-1:0] out_score;
    logic [HeldW-1:0]  held_before;
  } out_item_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_ROOT,
    CMD_UP_INIT,
    CMD_RD_PARENT,
    CMD_UP_MOVE,
    CMD_UP_WR,
    CMD_RD_LAST,
    CMD_DN_INIT,
    CMD_RD_LEFT,
    CMD_TAKE_LEFT,
    CMD_TAKE_RIGHT,
    CMD_DN_MOVE,
    CMD_DN_WR,
    CMD_MUL,
    CMD_OUT,
    CMD_OUT_EMPTY
  } dp_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_OF_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_EVICT,
    S_POP_LAST,
    S_POP_INIT,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_FIN,
    S_OUT,
    S_EMPTY
  } ctrl_state_t;

  typedef struct packed {
    logic is_pop;
    logic cnt_ge_k;
    logic cnt_zero;
    logic over_k;
    logic root_keeps;
    logic idx_zero;
    logic ent_less_rd;
    logic l_ge_n;
    logic r_lt_n;
    logic child_less_ent;
    logic out_busy;
  } dp_status_t;

  function automatic logic lesser(entry_t a, entry_t b);
    logic res;
    if (a.score != b.score) begin
      res = a.score < b.score;
    end else begin
      res = a.key > b.key;
    end
    return res;
  endfunction

endpackage

### src/tks_in_if.sv
// Input item channel: valid/ready handshake with the offer/pop payload.
interface tks_in_if;
  import tks_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/tks_out_if.sv
// Result channel: valid/ready handshake with the pop result payload.
interface tks_out_if;
  import tks_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/tks_dp.sv
// Datapath: heap memory, sift registers, ordering compares, boost multiply, result register.
module tks_dp #(
  parameter int CAPACITY = tks_pkg::CapacityDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tks_pkg::dp_cmd_t         cmd,
  input  tks_pkg::in_item_t        item,
  input  logic [tks_pkg::KeepW-1:0]  keep,
  input  logic [tks_pkg::BoostW-1:0] boost,
  output tks_pkg::dp_status_t      st,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tks_pkg::out_item_t       out_data
);
  import tks_pkg::*;

  localparam int Depth = CAPACITY + 1;
  localparam int IW    = $clog2(Depth);
  localparam int CW    = $clog2(CAPACITY + 2);
  localparam int XW    = CW + 1;
  localparam int KW    = (CW > KeepW) ? CW : KeepW;
  localparam int HW    = (CW > HeldW) ? CW : HeldW;

  entry_t mem [Depth];

  in_item_t           item_r;
  logic [CW-1:0]      cnt_r;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      cidx_r;
  entry_t             ent_r;
  entry_t             least_r;
  entry_t             child_r;
  entry_t             rdata_r;
  logic [CW-1:0]      held_r;
  logic [63:0]        prod_r;
  out_item_t          out_r;
  logic               out_valid_r;

  logic [KW-1:0]      keep_x;
  logic [KW-1:0]      k_eff;
  logic [KW-1:0]      cnt_k;
  logic [XW-1:0]      idx_x;
  logic [XW-1:0]      l_x;
  logic [XW-1:0]      n_x;
  logic [IW-1:0]      parent;
  logic [IW-1:0]      raddr;
  logic               we;
  logic [IW-1:0]      waddr;
  entry_t             wdata;
  entry_t             new_ent;
  logic [HW-1:0]      held_x;
  logic [ScoreW-1:0]  sat_score;

  always_comb begin
    keep_x = KW'(keep);
    if (keep_x == '0) begin
      k_eff = KW'(1);
    end else if (keep_x > KW'(CAPACITY)) begin
      k_eff = KW'(CAPACITY);
    end else begin
      k_eff = keep_x;
    end
  end

  assign cnt_k   = KW'(cnt_r);
  assign idx_x   = XW'(idx_r);
  assign l_x     = (idx_x << 1) + XW'(1);
  assign n_x     = XW'(cnt_r);
  assign parent  = IW'((idx_x - XW'(1)) >> 1);
  assign new_ent = '{key: item_r.term_key, score: item_r.score};
  assign held_x  = HW'(held_r);
  assign sat_score = (|prod_r[63:48]) ? '1 : prod_r[47:16];

  always_comb begin
    st.is_pop         = item_r.action == ActPop;
    st.cnt_ge_k       = cnt_k >= k_eff;
    st.cnt_zero       = cnt_r == '0;
    st.over_k         = cnt_k > k_eff;
    st.root_keeps     = item_r.score <= rdata_r.score;
    st.idx_zero       = idx_r == '0;
    st.ent_less_rd    = lesser(ent_r, rdata_r);
    st.l_ge_n         = l_x >= n_x;
    st.r_lt_n         = (l_x + XW'(1)) < n_x;
    st.child_less_ent = lesser(child_r, ent_r);
    st.out_busy       = out_valid_r;
  end

  always_comb begin
    case (cmd)
      CMD_RD_PARENT: raddr = parent;
      CMD_RD_LAST:   raddr = IW'(cnt_r - CW'(1));
      CMD_RD_LEFT:   raddr = IW'(l_x);
      CMD_TAKE_LEFT: raddr = IW'(l_x + XW'(1));
      default:       raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = ent_r;
    case (cmd)
      CMD_UP_MOVE: begin
        we    = 1'b1;
        wdata = rdata_r;
      end
      CMD_UP_WR:   we = 1'b1;
      CMD_DN_MOVE: begin
        we    = 1'b1;
        wdata = child_r;
      end
      CMD_DN_WR:   we = cnt_r != '0;
      default:     we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD:      item_r <= item;
      CMD_RD_ROOT:   held_r <= cnt_r;
      CMD_UP_INIT: begin
        idx_r <= IW'(cnt_r);
        ent_r <= new_ent;
      end
      CMD_UP_MOVE:   idx_r <= parent;
      CMD_RD_LAST:   least_r <= rdata_r;
      CMD_DN_INIT: begin
        ent_r <= rdata_r;
        idx_r <= '0;
      end
      CMD_TAKE_LEFT: begin
        child_r <= rdata_r;
        cidx_r  <= IW'(l_x);
      end
      CMD_TAKE_RIGHT: begin
        if (lesser(rdata_r, child_r)) begin
          child_r <= rdata_r;
          cidx_r  <= IW'(l_x + XW'(1));
        end
      end
      CMD_DN_MOVE:   idx_r <= cidx_r;
      CMD_MUL:       prod_r <= 64'(least_r.score) * 64'(boost);
      CMD_OUT: begin
        out_r.found       <= 1'b1;
        out_r.out_key     <= least_r.key;
        out_r.out_score   <= sat_score;
        out_r.held_before <= held_x[HeldW-1:0];
      end
      CMD_OUT_EMPTY: out_r <= '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == CMD_UP_WR) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd == CMD_DN_INIT) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd == CMD_OUT || cmd == CMD_OUT_EMPTY) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### src/tks_ctrl.sv
// Controller: state machine that sequences heap insert, sift-down and result output.
module tks_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tks_pkg::dp_status_t st,
  output tks_pkg::dp_cmd_t    cmd
);
  import tks_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        pop_out_r, pop_out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pop_out_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pop_out_r <= pop_out_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pop_out_nxt = pop_out_r;
    cmd         = CMD_NONE;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.is_pop) begin
          if (st.cnt_zero) begin
            state_nxt = S_EMPTY;
          end else begin
            pop_out_nxt = 1'b1;
            cmd         = CMD_RD_ROOT;
            state_nxt   = S_POP_LAST;
          end
        end else if (st.cnt_ge_k) begin
          cmd       = CMD_RD_ROOT;
          state_nxt = S_OF_CMP;
        end else begin
          cmd       = CMD_UP_INIT;
          state_nxt = S_UP_RD;
        end
      end
      S_OF_CMP: begin
        if (st.root_keeps) begin
          state_nxt = S_IDLE;
        end else begin
          cmd       = CMD_UP_INIT;
          state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (st.idx_zero) begin
          cmd       = CMD_UP_WR;
          state_nxt = S_EVICT;
        end else begin
          cmd       = CMD_RD_PARENT;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.ent_less_rd) begin
          cmd       = CMD_UP_MOVE;
          state_nxt = S_UP_RD;
        end else begin
          cmd       = CMD_UP_WR;
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        if (st.over_k) begin
          pop_out_nxt = 1'b0;
          cmd         = CMD_RD_ROOT;
          state_nxt   = S_POP_LAST;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_POP_LAST: begin
        cmd       = CMD_RD_LAST;
        state_nxt = S_POP_INIT;
      end
      S_POP_INIT: begin
        cmd       = CMD_DN_INIT;
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (st.l_ge_n) begin
          cmd       = CMD_DN_WR;
          state_nxt = S_FIN;
        end else begin
          cmd       = CMD_RD_LEFT;
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        cmd       = CMD_TAKE_LEFT;
        state_nxt = st.r_lt_n ? S_DN_R : S_DN_CMP;
      end
      S_DN_R: begin
        cmd       = CMD_TAKE_RIGHT;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (st.child_less_ent) begin
          cmd       = CMD_DN_MOVE;
          state_nxt = S_DN_CHK;
        end else begin
          cmd       = CMD_DN_WR;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (pop_out_r) begin
          cmd       = CMD_MUL;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd       = CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (!st.out_busy) begin
          cmd       = CMD_OUT_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### src/top_k_score_selector_core.sv
// Top level: keeps the k best (key, score) pairs in a bounded min-heap, pops with boost.
// One item is worked on at a time. An offer is either rejected against the
// minimum or inserted by a sift-up through the heap levels; when the
// insert pushes the count above k, an eviction adds a pop sift. A pop runs a
// sift-down through the heap levels, then the boost multiply and result load.
// The heap memory has one write port and one registered read port. A result
// waits in an output register; the next item is taken while it waits.
module top_k_score_selector_core #(
  parameter int CAPACITY = tks_pkg::CapacityDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tks_in_if.sink                        in_ch,
  tks_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tks_pkg::CfgAddrW-1:0]  paddr,
  input  logic [tks_pkg::CfgDataW-1:0]  pwdata,
  output logic [tks_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import tks_pkg::*;

  logic [KeepW-1:0]  keep_r;
  logic [BoostW-1:0] boost_r;
  logic              cfg_wr;
  dp_cmd_t           cmd;
  dp_status_t        st;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r  <= KeepReset;
      boost_r <= BoostReset;
    end else if (cfg_wr) begin
      if (paddr[2] == CfgKeep) begin
        keep_r <= pwdata[KeepW-1:0];
      end else begin
        boost_r <= pwdata[BoostW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == CfgBoost) ? boost_r : CfgDataW'(keep_r);

  tks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  tks_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .item      (in_ch.data),
    .keep      (keep_r),
    .boost     (boost_r),
    .st        (st),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item taken while previous item in flight");

  a_found_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.found |-> out_ch.data.held_before != '0)
    else $error("pop result reports empty store");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.found |->
      out_ch.data.held_before == '0 && out_ch.data.out_score == '0 &&
      out_ch.data.out_key == '0)
    else $error("empty pop result not cleared");

  a_no_cmd_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_OUT || cmd == CMD_OUT_EMPTY) |-> !out_ch.valid)
    else $error("result register overwritten");

endmodule
